// ===== rtl/core/sensor_reading_supervisor_macros.svh =====
// ----------------------------------------------------------------------------
// sensor reading supervisor assertion macros
// shorthand for clocked implications checked outside reset
// ----------------------------------------------------------------------------
`ifndef SENSOR_READING_SUPERVISOR_MACROS_SVH
`define SENSOR_READING_SUPERVISOR_MACROS_SVH

// same-cycle implication
`define SRS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srs check failed");

// next-cycle implication
`define SRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srs check failed");

`endif

// ===== rtl/core/srs_pkg.sv =====
// ----------------------------------------------------------------------------
// srs_pkg
// shared types, codes and constants of the sensor reading supervisor
// ----------------------------------------------------------------------------
package srs_pkg;

  typedef enum logic [2:0] {
    ST_FRESH      = 3'd0,
    ST_CACHED     = 3'd1,
    ST_FAILED     = 3'd2,
    ST_TEMP_RANGE = 3'd3,
    ST_HUM_RANGE  = 3'd4,
    ST_RECORD     = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_THROTTLE   = 3'd0,
    REG_FAIL_LIM   = 3'd1,
    REG_STUCK_LIM  = 3'd2,
    REG_REINIT_LIM = 3'd3,
    REG_TEMP_THR   = 3'd4,
    REG_HUM_THR    = 3'd5
  } reg_idx_e;

  localparam logic signed [11:0] TempMin   = -12'sd400;
  localparam logic signed [11:0] TempMax   = 12'sd800;
  localparam logic [10:0]        HumMax    = 11'd1000;
  localparam logic [3:0]         BadSat    = 4'd15;
  localparam logic [2:0]         ReinitSat = 3'd7;

  localparam logic [15:0] ThrottleRst  = 16'd2000;
  localparam logic [3:0]  FailLimRst   = 4'd5;
  localparam logic [3:0]  StuckLimRst  = 4'd15;
  localparam logic [2:0]  ReinitLimRst = 3'd3;
  localparam logic [9:0]  TempThrRst   = 10'd5;
  localparam logic [9:0]  HumThrRst    = 10'd20;

  typedef struct packed {
    logic [15:0] throttle_ms;
    logic [3:0]  fail_limit;
    logic [3:0]  stuck_limit;
    logic [2:0]  reinit_limit;
    logic [9:0]  temp_threshold;
    logic [9:0]  hum_threshold;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [31:0]        now_ms;
    logic               read_failed;
    logic signed [11:0] temperature;
    logic [10:0]        humidity;
    logic               sent_valid;
  } item_t;

  typedef struct packed {
    logic               valid_res;
    logic signed [11:0] temp_out;
    logic [10:0]        hum_out;
    status_e            status;
    logic               reinit_request;
    logic               restart_request;
    logic               significant_change;
  } result_t;

  typedef struct packed {
    logic [31:0]        last_read_time;
    logic               cache_valid;
    logic signed [11:0] cache_temp;
    logic [10:0]        cache_hum;
    logic signed [11:0] prev_temp;
    logic [10:0]        prev_hum;
    logic [3:0]         bad_count;
    logic [2:0]         reinit_count;
    logic signed [11:0] sent_temp;
    logic [10:0]        sent_hum;
    logic               first_report;
  } state_t;

endpackage

// ===== rtl/core/srs_eval.sv =====
// ----------------------------------------------------------------------------
// srs_eval
// per-item decision logic: throttle, checks, stuck detection and deadbands
// ----------------------------------------------------------------------------
module srs_eval (
  input  srs_pkg::cfg_t    cfg_i,
  input  srs_pkg::item_t   item_i,
  input  srs_pkg::state_t  state_i,
  output srs_pkg::result_t res_o,
  output srs_pkg::state_t  state_o
);

  logic [31:0]        elapsed;
  logic               use_cache;
  logic signed [11:0] cmp_temp;
  logic [10:0]        cmp_hum;
  logic signed [12:0] dt;
  logic [11:0]        adt;
  logic [11:0]        dh;
  logic [10:0]        adh;
  logic               changed;
  logic [3:0]         bad_inc;
  logic [2:0]         rc_inc;
  logic               temp_bad;
  logic               hum_bad;
  logic               same;

  assign elapsed   = item_i.now_ms - state_i.last_read_time;
  assign use_cache = (elapsed < {16'd0, cfg_i.throttle_ms}) && state_i.cache_valid;

  // deadband check runs on whichever sample gets reported
  assign cmp_temp = use_cache ? state_i.cache_temp : item_i.temperature;
  assign cmp_hum  = use_cache ? state_i.cache_hum : item_i.humidity;
  assign dt  = {cmp_temp[11], cmp_temp} - {state_i.sent_temp[11], state_i.sent_temp};
  assign adt = dt[12] ? 12'(-dt) : dt[11:0];
  assign dh  = {1'b0, cmp_hum} - {1'b0, state_i.sent_hum};
  assign adh = dh[11] ? 11'(-dh) : dh[10:0];
  assign changed = state_i.first_report || (adt >= {2'd0, cfg_i.temp_threshold})
                   || (adh >= {1'b0, cfg_i.hum_threshold});

  assign bad_inc  = (state_i.bad_count < srs_pkg::BadSat) ? state_i.bad_count + 4'd1
                                                          : state_i.bad_count;
  assign rc_inc   = (state_i.reinit_count < srs_pkg::ReinitSat) ? state_i.reinit_count + 3'd1
                                                                : state_i.reinit_count;
  assign temp_bad = (item_i.temperature < srs_pkg::TempMin)
                    || (item_i.temperature > srs_pkg::TempMax);
  assign hum_bad  = item_i.humidity > srs_pkg::HumMax;
  assign same     = (item_i.temperature == state_i.prev_temp)
                    && (item_i.humidity == state_i.prev_hum);

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    if (item_i.cmd) begin
      res_o.status = srs_pkg::ST_RECORD;
      if (item_i.sent_valid) begin
        state_o.sent_temp    = item_i.temperature;
        state_o.sent_hum     = item_i.humidity;
        state_o.first_report = 1'b0;
      end
    end else if (use_cache) begin
      res_o.valid_res          = 1'b1;
      res_o.temp_out           = state_i.cache_temp;
      res_o.hum_out            = state_i.cache_hum;
      res_o.status             = srs_pkg::ST_CACHED;
      res_o.significant_change = changed;
    end else begin
      state_o.last_read_time = item_i.now_ms;
      if (item_i.read_failed) begin
        res_o.status = srs_pkg::ST_FAILED;
        if (bad_inc >= cfg_i.fail_limit) begin
          res_o.reinit_request = 1'b1;
          state_o.bad_count    = '0;
        end else begin
          state_o.bad_count = bad_inc;
        end
      end else if (temp_bad) begin
        res_o.status = srs_pkg::ST_TEMP_RANGE;
      end else if (hum_bad) begin
        res_o.status = srs_pkg::ST_HUM_RANGE;
      end else begin
        if (same) begin
          if (bad_inc >= cfg_i.stuck_limit) begin
            res_o.reinit_request  = 1'b1;
            res_o.restart_request = rc_inc >= cfg_i.reinit_limit;
            state_o.bad_count     = '0;
            state_o.reinit_count  = rc_inc;
          end else begin
            state_o.bad_count = bad_inc;
          end
        end else begin
          state_o.bad_count    = '0;
          state_o.reinit_count = '0;
        end
        state_o.prev_temp        = item_i.temperature;
        state_o.prev_hum         = item_i.humidity;
        state_o.cache_temp       = item_i.temperature;
        state_o.cache_hum        = item_i.humidity;
        state_o.cache_valid      = 1'b1;
        res_o.valid_res          = 1'b1;
        res_o.temp_out           = item_i.temperature;
        res_o.hum_out            = item_i.humidity;
        res_o.status             = srs_pkg::ST_FRESH;
        res_o.significant_change = changed;
      end
    end
  end

endmodule

// ===== rtl/core/sensor_reading_supervisor.sv =====
// ----------------------------------------------------------------------------
// sensor_reading_supervisor
// throttled, range-checked and stuck-monitored temperature/humidity reads
// ----------------------------------------------------------------------------
// path: an accepted request is held in the input register, evaluated by the decision
// logic and presented from the result register until the receiver takes it
// throughput: one request per cycle while the output is not stalled, set by the combinational decision logic
// reset: asynchronous, clears pipeline and supervision state, loads default
// register values; no clearing pass, first request accepted right after reset
module sensor_reading_supervisor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [31:0]        now_ms_i,
  input  logic               read_failed_i,
  input  logic signed [11:0] temperature_i,
  input  logic [10:0]        humidity_i,
  input  logic               sent_valid_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               valid_res_o,
  output logic signed [11:0] temp_out_o,
  output logic [10:0]        hum_out_o,
  output logic [2:0]         status_o,
  output logic               reinit_request_o,
  output logic               restart_request_o,
  output logic               significant_change_o
);

  srs_pkg::cfg_t    cfg_q;
  srs_pkg::item_t   item_q;
  logic             item_valid_q;
  srs_pkg::state_t  state_q, state_d;
  srs_pkg::result_t res_q, res_d;
  logic             res_valid_q;
  logic             advance;
  logic             in_take;
  logic             move;

  assign advance    = !res_valid_q || !out_stall_i;
  assign move       = item_valid_q && advance;
  assign in_stall_o = item_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.throttle_ms    <= srs_pkg::ThrottleRst;
      cfg_q.fail_limit     <= srs_pkg::FailLimRst;
      cfg_q.stuck_limit    <= srs_pkg::StuckLimRst;
      cfg_q.reinit_limit   <= srs_pkg::ReinitLimRst;
      cfg_q.temp_threshold <= srs_pkg::TempThrRst;
      cfg_q.hum_threshold  <= srs_pkg::HumThrRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        srs_pkg::REG_THROTTLE:   cfg_q.throttle_ms    <= cfg_data_i;
        srs_pkg::REG_FAIL_LIM:   cfg_q.fail_limit     <= cfg_data_i[3:0];
        srs_pkg::REG_STUCK_LIM:  cfg_q.stuck_limit    <= cfg_data_i[3:0];
        srs_pkg::REG_REINIT_LIM: cfg_q.reinit_limit   <= cfg_data_i[2:0];
        srs_pkg::REG_TEMP_THR:   cfg_q.temp_threshold <= cfg_data_i[9:0];
        srs_pkg::REG_HUM_THR:    cfg_q.hum_threshold  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_take) begin
      item_valid_q <= 1'b1;
    end else if (move) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.cmd         <= cmd_i;
      item_q.now_ms      <= now_ms_i;
      item_q.read_failed <= read_failed_i;
      item_q.temperature <= temperature_i;
      item_q.humidity    <= humidity_i;
      item_q.sent_valid  <= sent_valid_i;
    end
  end

  srs_eval u_eval (
    .cfg_i   (cfg_q),
    .item_i  (item_q),
    .state_i (state_q),
    .res_o   (res_d),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{first_report: 1'b1, default: '0};
    end else if (move) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = res_valid_q;
  assign valid_res_o          = res_q.valid_res;
  assign temp_out_o           = res_q.temp_out;
  assign hum_out_o            = res_q.hum_out;
  assign status_o             = res_q.status;
  assign reinit_request_o     = res_q.reinit_request;
  assign restart_request_o    = res_q.restart_request;
  assign significant_change_o = res_q.significant_change;

endmodule

// ===== rtl/core/srs_checker.sv =====
// ----------------------------------------------------------------------------
// srs_checker
// port-level checks on the sensor reading supervisor results
// ----------------------------------------------------------------------------
`include "sensor_reading_supervisor_macros.svh"

module srs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               valid_res_o,
  input logic signed [11:0] temp_out_o,
  input logic [10:0]        hum_out_o,
  input logic [2:0]         status_o,
  input logic               reinit_request_o,
  input logic               restart_request_o,
  input logic               significant_change_o
);

  // usable readings only come from fresh or cached reads
  `SRS_ASSERT_NOW(a_valid_status, out_valid_o && valid_res_o, status_o == srs_pkg::ST_FRESH || status_o == srs_pkg::ST_CACHED)

  // rejected results carry no sample and no change flag
  `SRS_ASSERT_NOW(a_invalid_zero, out_valid_o && !valid_res_o, temp_out_o == 12'sd0 && hum_out_o == 11'd0 && !significant_change_o)

  // restart only comes with a stuck reinit on a fresh read
  `SRS_ASSERT_NOW(a_restart_reinit, out_valid_o && restart_request_o, reinit_request_o && status_o == srs_pkg::ST_FRESH)

  // stalled result stays put
  `SRS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(temp_out_o) && $stable(hum_out_o))

endmodule

bind sensor_reading_supervisor srs_checker u_srs_checker (.*);

// ===== bench/sensor_reading_supervisor_tb.sv =====
// ----------------------------------------------------------------------------
// sensor_reading_supervisor_tb
// self-checking bench: requests from directed and random sensor traffic are
// run through a cycle-free model of the supervisor, and every response is
// compared field by field in order, under random stalls on both sides
// ----------------------------------------------------------------------------
module sensor_reading_supervisor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int IdlePct    = 37;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               cmd_i;
  logic [31:0]        now_ms_i;
  logic               read_failed_i;
  logic signed [11:0] temperature_i;
  logic [10:0]        humidity_i;
  logic               sent_valid_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               valid_res_o;
  logic signed [11:0] temp_out_o;
  logic [10:0]        hum_out_o;
  logic [2:0]         status_o;
  logic               reinit_request_o;
  logic               restart_request_o;
  logic               significant_change_o;

  sensor_reading_supervisor dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .cmd_i               (cmd_i),
    .now_ms_i            (now_ms_i),
    .read_failed_i       (read_failed_i),
    .temperature_i       (temperature_i),
    .humidity_i          (humidity_i),
    .sent_valid_i        (sent_valid_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .valid_res_o         (valid_res_o),
    .temp_out_o          (temp_out_o),
    .hum_out_o           (hum_out_o),
    .status_o            (status_o),
    .reinit_request_o    (reinit_request_o),
    .restart_request_o   (restart_request_o),
    .significant_change_o(significant_change_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // supervisor model: registers and state
  srs_pkg::cfg_t      model_cfg;
  logic [31:0]        last_rd_ms;
  logic               cache_ok;
  logic signed [11:0] cache_t;
  logic [10:0]        cache_h;
  logic signed [11:0] prev_t;
  logic [10:0]        prev_h;
  logic [3:0]         bad_cnt;
  logic [2:0]         reinit_cnt;
  logic signed [11:0] sent_t;
  logic [10:0]        sent_h;
  logic               first_rep;

  srs_pkg::result_t reports_due[$];
  srs_pkg::result_t head_report;
  int      mismatch_cnt = 0;
  int      cycle_cnt = 0;

  // traffic shaping
  bit                 send_idle = 1'b1;
  bit                 recv_idle = 1'b1;
  int                 hold_len = 0;
  int                 hold_seq = 0;
  int                 hold_seen = 0;
  int                 hold_left = 0;
  int                 mix_repeat_pct, mix_fail_pct, mix_record_pct, mix_wild_pct;
  int                 step_max_ms = 3020;
  logic [31:0]        stim_ms = '0;
  logic signed [11:0] good_t = 12'sd200;
  logic [10:0]        good_h = 11'd400;

  task automatic reset_supervision_model();
    model_cfg.throttle_ms    = srs_pkg::ThrottleRst;
    model_cfg.fail_limit     = srs_pkg::FailLimRst;
    model_cfg.stuck_limit    = srs_pkg::StuckLimRst;
    model_cfg.reinit_limit   = srs_pkg::ReinitLimRst;
    model_cfg.temp_threshold = srs_pkg::TempThrRst;
    model_cfg.hum_threshold  = srs_pkg::HumThrRst;
    last_rd_ms = '0;
    cache_ok   = 1'b0;
    cache_t    = '0;
    cache_h    = '0;
    prev_t     = '0;
    prev_h     = '0;
    bad_cnt    = '0;
    reinit_cnt = '0;
    sent_t     = '0;
    sent_h     = '0;
    first_rep  = 1'b1;
  endtask

  function automatic logic beyond_deadband(logic signed [11:0] t, logic [10:0] h);
    int dt, dh;
    dt = int'(t) - int'(sent_t);
    if (dt < 0) dt = -dt;
    dh = int'(h) - int'(sent_h);
    if (dh < 0) dh = -dh;
    return first_rep || dt >= int'(model_cfg.temp_threshold) ||
           dh >= int'(model_cfg.hum_threshold);
  endfunction

  function automatic srs_pkg::result_t supervise_reading(srs_pkg::item_t it);
    srs_pkg::result_t   r;
    logic [31:0]        since;
    logic signed [11:0] t;
    r = '0;
    t = it.temperature;
    if (it.cmd) begin
      if (it.sent_valid) begin
        sent_t    = it.temperature;
        sent_h    = it.humidity;
        first_rep = 1'b0;
      end
      r.status = srs_pkg::ST_RECORD;
      return r;
    end
    since = it.now_ms - last_rd_ms;
    // inside the throttle window the cached sample is served, no counters move
    if (cache_ok && since < {16'd0, model_cfg.throttle_ms}) begin
      r.valid_res          = 1'b1;
      r.temp_out           = cache_t;
      r.hum_out            = cache_h;
      r.status             = srs_pkg::ST_CACHED;
      r.significant_change = beyond_deadband(cache_t, cache_h);
      return r;
    end
    last_rd_ms = it.now_ms;
    if (it.read_failed) begin
      if (bad_cnt != srs_pkg::BadSat) bad_cnt = bad_cnt + 4'd1;
      if (bad_cnt >= model_cfg.fail_limit) begin
        r.reinit_request = 1'b1;
        bad_cnt          = '0;
      end
      r.status = srs_pkg::ST_FAILED;
      return r;
    end
    if (t < srs_pkg::TempMin || t > srs_pkg::TempMax) begin
      r.status = srs_pkg::ST_TEMP_RANGE;
      return r;
    end
    if (it.humidity > srs_pkg::HumMax) begin
      r.status = srs_pkg::ST_HUM_RANGE;
      return r;
    end
    if (t == prev_t && it.humidity == prev_h) begin
      // shared counter with failed reads
      if (bad_cnt != srs_pkg::BadSat) bad_cnt = bad_cnt + 4'd1;
      if (bad_cnt >= model_cfg.stuck_limit) begin
        r.reinit_request = 1'b1;
        bad_cnt          = '0;
        if (reinit_cnt != srs_pkg::ReinitSat) reinit_cnt = reinit_cnt + 3'd1;
        if (reinit_cnt >= model_cfg.reinit_limit) r.restart_request = 1'b1;
      end
    end else begin
      bad_cnt    = '0;
      reinit_cnt = '0;
    end
    prev_t   = t;
    prev_h   = it.humidity;
    cache_t  = t;
    cache_h  = it.humidity;
    cache_ok = 1'b1;
    r.valid_res          = 1'b1;
    r.temp_out           = t;
    r.hum_out            = it.humidity;
    r.status             = srs_pkg::ST_FRESH;
    r.significant_change = beyond_deadband(t, it.humidity);
    return r;
  endfunction

  // entered and left at a falling edge; valid stays high between back-to-back requests
  task automatic send_reading(srs_pkg::item_t it);
    while (send_idle && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    cmd_i         <= it.cmd;
    now_ms_i      <= it.now_ms;
    read_failed_i <= it.read_failed;
    temperature_i <= it.temperature;
    humidity_i    <= it.humidity;
    sent_valid_i  <= it.sent_valid;
    do @(posedge clk_i); while (in_stall_o);
    reports_due.push_back(supervise_reading(it));
    @(negedge clk_i);
  endtask

  task automatic send_fields(logic cmd, logic [31:0] now, logic failed,
                             logic signed [11:0] t, logic [10:0] h, logic sv);
    srs_pkg::item_t it;
    it.cmd         = cmd;
    it.now_ms      = now;
    it.read_failed = failed;
    it.temperature = t;
    it.humidity    = h;
    it.sent_valid  = sv;
    send_reading(it);
  endtask

  task automatic next_reading(output srs_pkg::item_t it);
    int pick;
    int v;
    it             = '0;
    it.sent_valid  = 1'($urandom_range(1));
    it.read_failed = ($urandom_range(99) < mix_fail_pct);
    if ($urandom_range(99) < mix_record_pct) begin
      it.cmd         = 1'b1;
      it.now_ms      = $urandom;
      it.temperature = $urandom_range(1) ? good_t : 12'($urandom);
      it.humidity    = $urandom_range(1) ? good_h : 11'($urandom);
      return;
    end
    pick = $urandom_range(19);
    if (pick == 0) stim_ms = $urandom;
    else if (pick > 2) stim_ms = stim_ms + 32'($urandom_range(step_max_ms));
    it.now_ms = stim_ms;
    pick = $urandom_range(99);
    if (pick < mix_wild_pct) begin
      it.temperature = 12'($urandom);
      it.humidity    = 11'($urandom);
      return;
    end
    if (pick >= mix_wild_pct + mix_repeat_pct) begin
      if (pick < 85) begin
        v = int'(good_t) + int'($urandom_range(40)) - 20;
        if (v < -400) v = -400;
        if (v > 800) v = 800;
        good_t = 12'(v);
        v = int'(good_h) + int'($urandom_range(60)) - 30;
        if (v < 0) v = 0;
        if (v > 1000) v = 1000;
        good_h = 11'(v);
      end else begin
        good_t = 12'(int'($urandom_range(1200)) - 400);
        good_h = 11'($urandom_range(1000));
      end
    end
    it.temperature = good_t;
    it.humidity    = good_h;
  endtask

  task automatic run_readings(int n);
    srs_pkg::item_t it;
    repeat (n) begin
      next_reading(it);
      send_reading(it);
    end
  endtask

  task automatic set_mix(int repeat_pct, int fail_pct, int record_pct, int wild_pct);
    mix_repeat_pct = repeat_pct;
    mix_fail_pct   = fail_pct;
    mix_record_pct = record_pct;
    mix_wild_pct   = wild_pct;
  endtask

  // sender goes quiet until every response is back, then waits a little longer
  task automatic drain_block();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (reports_due.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(srs_pkg::reg_idx_e idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      srs_pkg::REG_THROTTLE:   model_cfg.throttle_ms    = val;
      srs_pkg::REG_FAIL_LIM:   model_cfg.fail_limit     = val[3:0];
      srs_pkg::REG_STUCK_LIM:  model_cfg.stuck_limit    = val[3:0];
      srs_pkg::REG_REINIT_LIM: model_cfg.reinit_limit   = val[2:0];
      srs_pkg::REG_TEMP_THR:   model_cfg.temp_threshold = val[9:0];
      srs_pkg::REG_HUM_THR:    model_cfg.hum_threshold  = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [15:0] thr_ms, logic [3:0] fail_lim,
                            logic [3:0] stuck_lim, logic [2:0] reinit_lim,
                            logic [9:0] t_thr, logic [9:0] h_thr);
    drain_block();
    write_reg(srs_pkg::REG_THROTTLE, thr_ms);
    write_reg(srs_pkg::REG_FAIL_LIM, {12'd0, fail_lim});
    write_reg(srs_pkg::REG_STUCK_LIM, {12'd0, stuck_lim});
    write_reg(srs_pkg::REG_REINIT_LIM, {13'd0, reinit_lim});
    write_reg(srs_pkg::REG_TEMP_THR, {6'd0, t_thr});
    write_reg(srs_pkg::REG_HUM_THR, {6'd0, h_thr});
    // steps straddle the window so both cached and real reads occur
    step_max_ms = int'(thr_ms) * 3 / 2 + 20;
  endtask

  task automatic random_config();
    logic [15:0] thr_ms;
    case ($urandom_range(3))
      0: thr_ms = '0;
      1: thr_ms = 16'($urandom_range(50));
      2: thr_ms = 16'($urandom_range(3000));
      default: thr_ms = 16'($urandom);
    endcase
    set_config(thr_ms, 4'($urandom_range(1, 15)), 4'($urandom_range(1, 15)),
               3'($urandom_range(1, 7)),
               $urandom_range(1) ? 10'($urandom_range(60)) : 10'($urandom),
               $urandom_range(1) ? 10'($urandom_range(60)) : 10'($urandom));
  endtask

  task automatic test_directed_cases();
    send_fields(1'b0, 32'd0, 1'b0, 12'sd215, 11'd450, 1'b0);
    send_fields(1'b0, 32'd100, 1'b0, 12'sd300, 11'd300, 1'b0);
    send_fields(1'b1, 32'd120, 1'b0, 12'sd215, 11'd450, 1'b0);
    send_fields(1'b1, 32'd130, 1'b1, 12'sd215, 11'd450, 1'b1);
    // failed flag ignored while the cache is served
    send_fields(1'b0, 32'd150, 1'b1, 12'sd0, 11'd0, 1'b0);
    send_fields(1'b0, 32'd2100, 1'b0, 12'sd215, 11'd450, 1'b0);
    send_fields(1'b0, 32'd4100, 1'b1, 12'sd215, 11'd450, 1'b0);
    send_fields(1'b0, 32'd6100, 1'b0, -12'sd400, 11'd0, 1'b0);
    send_fields(1'b0, 32'd8100, 1'b0, 12'sd800, 11'd1000, 1'b0);
    send_fields(1'b0, 32'd10100, 1'b0, -12'sd401, 11'd500, 1'b0);
    send_fields(1'b0, 32'd12100, 1'b0, 12'sd801, 11'd500, 1'b0);
    send_fields(1'b0, 32'd14100, 1'b0, -12'sd2048, 11'd2047, 1'b1);
    send_fields(1'b0, 32'd16100, 1'b0, 12'sd2047, 11'd0, 1'b0);
    send_fields(1'b0, 32'd18100, 1'b0, 12'sd0, 11'd1001, 1'b0);
    send_fields(1'b0, 32'd20100, 1'b0, 12'sd0, 11'd2047, 1'b0);
    send_fields(1'b0, 32'd22100, 1'b1, -12'sd2048, 11'd2047, 1'b1);
    send_fields(1'b0, 32'hFFFF_FF00, 1'b0, 12'sd100, 11'd500, 1'b0);
    // elapsed time wraps past zero and stays inside the window
    send_fields(1'b0, 32'h0000_0100, 1'b0, 12'sd1, 11'd1, 1'b0);
    send_fields(1'b0, 32'hFFFF_FE00, 1'b0, 12'sd100, 11'd500, 1'b0);
    send_fields(1'b1, 32'hFFFF_FFFF, 1'b1, -12'sd2048, 11'd2047, 1'b1);
    send_fields(1'b0, 32'h0000_0A00, 1'b0, 12'sd103, 11'd520, 1'b1);
    send_fields(1'b0, 32'h0000_0A01, 1'b0, 12'sd0, 11'd0, 1'b0);
    send_fields(1'b1, 32'h0000_0A02, 1'b0, 12'sd103, 11'd520, 1'b1);
    send_fields(1'b0, 32'h0000_2000, 1'b0, 12'sd104, 11'd521, 1'b0);
    // temperature exactly on the deadband edge
    send_fields(1'b0, 32'h0000_3000, 1'b0, 12'sd108, 11'd520, 1'b0);
  endtask

  task automatic test_register_extremes();
    set_mix(15, 10, 10, 10);
    set_config(16'd0, 4'd1, 4'd1, 3'd1, 10'd0, 10'd0);
    run_readings(60);
    set_config(16'hFFFF, 4'd15, 4'd15, 3'd7, 10'd1023, 10'd1023);
    run_readings(60);
    // zero limits raise the request on every increment
    set_config(16'd0, 4'd0, 4'd0, 3'd0, 10'd0, 10'd0);
    run_readings(60);
    set_config(16'd1, 4'd15, 4'd1, 3'd7, 10'd1, 10'd1);
    run_readings(60);
    set_config(srs_pkg::ThrottleRst, srs_pkg::FailLimRst, srs_pkg::StuckLimRst,
               srs_pkg::ReinitLimRst, srs_pkg::TempThrRst, srs_pkg::HumThrRst);
    run_readings(60);
  endtask

  task automatic test_stuck_sensor();
    set_mix(80, 5, 5, 5);
    set_config(16'd0, 4'd15, 4'd3, 3'd2, 10'd5, 10'd20);
    run_readings(200);
    // long identical runs reach the largest limits and saturate the reinit count
    set_mix(98, 0, 1, 0);
    set_config(16'd0, 4'd15, 4'd15, 3'd7, 10'd5, 10'd20);
    run_readings(250);
  endtask

  task automatic test_failed_reads();
    set_mix(40, 60, 5, 5);
    set_config(16'd0, 4'd3, 4'd4, 3'd2, 10'd5, 10'd20);
    run_readings(75);
    set_config(16'd0, 4'd15, 4'd15, 3'd3, 10'd5, 10'd20);
    run_readings(75);
  endtask

  task automatic test_receiver_holdoff();
    set_mix(15, 10, 10, 10);
    send_idle = 1'b0;
    hold_len  = 200;
    hold_seq  = hold_seq + 1;
    run_readings(60);
    send_idle = 1'b1;
    hold_len  = 120;
    hold_seq  = hold_seq + 1;
    run_readings(60);
  endtask

  task automatic test_sender_pause();
    set_mix(15, 10, 10, 10);
    repeat (4) begin
      run_readings(15);
      drain_block();
    end
  endtask

  task automatic test_random_traffic();
    set_mix(15, 10, 10, 10);
    for (int p = 0; p < 5; p++) begin
      random_config();
      // first phase runs with no idling on either side
      send_idle = (p != 0);
      recv_idle = (p != 0);
      run_readings(130);
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  // receiver side: random stall plus counted hold-off stretches
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= recv_idle && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reports_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
          $display("%0t: response with no request pending: valid=%0d temp=%0d hum=%0d st=%0d",
                   $realtime, valid_res_o, temp_out_o, hum_out_o, status_o);
        end
      end else begin
        head_report = reports_due.pop_front();
        if (valid_res_o !== head_report.valid_res || temp_out_o !== head_report.temp_out ||
            hum_out_o !== head_report.hum_out || status_o !== 3'(head_report.status) ||
            reinit_request_o !== head_report.reinit_request ||
            restart_request_o !== head_report.restart_request ||
            significant_change_o !== head_report.significant_change) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("%0t: expected valid=%0d temp=%0d hum=%0d st=%0d reinit=%0d restart=%0d chg=%0d",
                     $realtime, head_report.valid_res, head_report.temp_out,
                     head_report.hum_out, 3'(head_report.status), head_report.reinit_request,
                     head_report.restart_request, head_report.significant_change);
            $display("%0t: got      valid=%0d temp=%0d hum=%0d st=%0d reinit=%0d restart=%0d chg=%0d",
                     $realtime, valid_res_o, temp_out_o, hum_out_o, status_o,
                     reinit_request_o, restart_request_o, significant_change_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("[sensor_reading_supervisor] ERROR");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    cmd_i         = 1'b0;
    now_ms_i      = '0;
    read_failed_i = 1'b0;
    temperature_i = '0;
    humidity_i    = '0;
    sent_valid_i  = 1'b0;
    set_mix(15, 10, 10, 10);
    reset_supervision_model();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_register_extremes();
    test_stuck_sensor();
    test_failed_reads();
    test_receiver_holdoff();
    test_sender_pause();
    test_random_traffic();

    drain_block();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && reports_due.size() == 0) begin
      $display("[sensor_reading_supervisor] OK");
    end else begin
      $display("[sensor_reading_supervisor] ERROR");
    end
    $finish;
  end

endmodule
